[sv/d2cf_pkg.sv]
package d2cf_pkg;

    localparam int SigBits  = 52;
    localparam int DBias    = 1023;
    localparam int DExpBits = 11;

    // Stage 1 to stage 2 payload
    typedef struct packed {
        logic        sign;
        logic        special;   // infinity or NaN input
        logic        is_zero;
        logic        is_nan;
        logic [51:0] mant;
        logic [52:0] sig;       // normalized so bit 52 is the leading one
        logic signed [12:0] x;  // unbiased exponent of leading bit
        logic [3:0]  e;
        logic [5:0]  f;
    } d2cf_s1_t;

    // Stage 2 to stage 3 payload
    typedef struct packed {
        logic        sign;
        logic        special;
        logic        is_zero;
        logic        is_nan;
        logic        subn;
        logic [51:0] mant;
        logic [52:0] sig;
        logic [6:0]  shift;     // right shift amount before rounding
        logic signed [12:0] x;
        logic [3:0]  e;
        logic [5:0]  f;
    } d2cf_s2_t;

endpackage

[sv/double_to_custom_float.sv]
// Binary64 to parametric minifloat converter, round to nearest even.
// Throughput: one transaction per cycle; three-stage pipeline stalls as a whole
// when the result register is full and not taken.
// Reset: synchronous active-low aresetn clears all stage valid bits.
module double_to_custom_float
    import d2cf_pkg::*;
#(
    parameter int MAX_EXP_BITS  = 11,
    parameter int MAX_FRAC_BITS = 52
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic [3:0]  s_exp_bits,
    input  logic [5:0]  s_frac_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_sign_out,
    output logic [10:0] m_exponent_field,
    output logic [51:0] m_fraction_field,
    output logic        m_overflowed
);

    logic     v1, v2, advance;
    d2cf_s1_t d1;
    d2cf_s2_t d2;

    // Advance whole pipe unless the output holds an untaken result
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    d2cf_norm #(
        .MAX_EXP_BITS (MAX_EXP_BITS),
        .MAX_FRAC_BITS(MAX_FRAC_BITS)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .advance   (advance),
        .value_bits(s_value_bits),
        .exp_bits  (s_exp_bits),
        .frac_bits (s_frac_bits),
        .out_valid (v1),
        .out_data  (d1)
    );

    d2cf_align u_align (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v1),
        .advance  (advance),
        .in_data  (d1),
        .out_valid(v2),
        .out_data (d2)
    );

    d2cf_round u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (v2),
        .advance  (advance),
        .in_data  (d2),
        .out_valid(m_valid),
        .out_sign (m_sign_out),
        .out_exp  (m_exponent_field),
        .out_frac (m_fraction_field),
        .out_ovf  (m_overflowed)
    );

endmodule

[sv/d2cf_norm.sv]
module d2cf_norm
    import d2cf_pkg::*;
#(
    parameter int MAX_EXP_BITS  = 11,
    parameter int MAX_FRAC_BITS = 52
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        advance,
    input  logic [63:0] value_bits,
    input  logic [3:0]  exp_bits,
    input  logic [5:0]  frac_bits,
    output logic        out_valid,
    output d2cf_s1_t    out_data
);

    d2cf_s1_t data_next, data_reg;
    logic     valid_reg;

    logic [10:0] dexp;
    logic [51:0] mant;
    logic [52:0] sig_raw;
    logic [5:0]  lz;
    logic        found;

    // Clamp format and count leading zeros of the significand
    always_comb begin
        dexp    = value_bits[62:52];
        mant    = value_bits[51:0];
        sig_raw = {(dexp != '0), mant};
        lz      = '0;
        found   = 1'b0;
        for (int i = 52; i >= 0; i--) begin
            if (!found && sig_raw[i]) begin
                lz    = 6'(52 - i);
                found = 1'b1;
            end
        end
        data_next.sign    = value_bits[63];
        data_next.special = (dexp == '1);
        data_next.is_zero = (dexp == '0) && (mant == '0);
        data_next.is_nan  = (dexp == '1) && (mant != '0);
        data_next.mant    = mant;
        data_next.sig     = sig_raw << lz;
        data_next.x       = (dexp == '0) ? 13'sd1 - 13'(DBias) - $signed({7'd0, lz})
                                         : $signed({2'd0, dexp}) - 13'(DBias);
        if (exp_bits < 4'd2)
            data_next.e = 4'd2;
        else if (exp_bits > 4'(MAX_EXP_BITS))
            data_next.e = 4'(MAX_EXP_BITS);
        else
            data_next.e = exp_bits;
        if (frac_bits < 6'd1)
            data_next.f = 6'd1;
        else if (frac_bits > 6'(MAX_FRAC_BITS))
            data_next.f = 6'(MAX_FRAC_BITS);
        else
            data_next.f = frac_bits;
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/d2cf_align.sv]
module d2cf_align
    import d2cf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  logic     advance,
    input  d2cf_s1_t in_data,
    output logic     out_valid,
    output d2cf_s2_t out_data
);

    d2cf_s2_t data_next, data_reg;
    logic     valid_reg;
    logic signed [12:0] emin;
    logic signed [12:0] sh;

    // Pick normal or subnormal alignment and its shift
    always_comb begin
        emin = 13'sd2 - $signed(13'(13'd1 << (in_data.e - 4'd1)));
        data_next.sign    = in_data.sign;
        data_next.special = in_data.special;
        data_next.is_zero = in_data.is_zero;
        data_next.is_nan  = in_data.is_nan;
        data_next.mant    = in_data.mant;
        data_next.sig     = in_data.sig;
        data_next.x       = in_data.x;
        data_next.e       = in_data.e;
        data_next.f       = in_data.f;
        data_next.subn    = in_data.x < emin;
        if (in_data.x < emin)
            sh = 13'sd52 - $signed({7'd0, in_data.f}) + (emin - in_data.x);
        else
            sh = 13'sd52 - $signed({7'd0, in_data.f});
        data_next.shift = (sh > 13'sd64) ? 7'd64 : 7'(sh);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[sv/d2cf_round.sv]
module d2cf_round
    import d2cf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        advance,
    input  d2cf_s2_t    in_data,
    output logic        out_valid,
    output logic        out_sign,
    output logic [10:0] out_exp,
    output logic [51:0] out_frac,
    output logic        out_ovf
);

    logic        valid_reg, sign_reg, ovf_reg;
    logic [10:0] exp_reg;
    logic [51:0] frac_reg;
    logic        sign_next, ovf_next;
    logic [10:0] exp_next;
    logic [51:0] frac_next;

    logic [53:0] q;
    logic [63:0] rem, half;
    logic [51:0] fmask;
    logic [10:0] allones;
    logic signed [12:0] bias, xr;
    logic        carry;

    // Round to nearest even, then encode
    always_comb begin
        fmask   = 52'((53'd1 << in_data.f) - 53'd1);
        allones = 11'((12'd1 << in_data.e) - 12'd1);
        bias    = $signed(13'(13'd1 << (in_data.e - 4'd1))) - 13'sd1;
        if (in_data.shift >= 7'd64) begin
            q = '0; rem = '0; half = '1;
        end else begin
            q    = 54'(in_data.sig >> in_data.shift);
            rem  = 64'(in_data.sig) & ((64'd1 << in_data.shift) - 64'd1);
            half = (in_data.shift == '0) ? '1 : (64'd1 << (in_data.shift - 7'd1));
        end
        if (in_data.shift != '0 && (rem > half || (rem == half && q[0])))
            q = q + 54'd1;
        carry     = (q >> (in_data.f + 6'd1)) != '0;
        xr        = in_data.x + (carry ? 13'sd1 : 13'sd0);
        sign_next = in_data.sign;
        ovf_next  = 1'b0;
        exp_next  = '0;
        frac_next = '0;
        if (in_data.special) begin
            exp_next = allones;
            if (in_data.is_nan) begin
                frac_next = (in_data.mant >> (6'd52 - in_data.f)) & fmask;
                if (frac_next == '0)
                    frac_next = 52'd1 << (in_data.f - 6'd1);
            end
        end else if (in_data.is_zero) begin
            exp_next = '0;
        end else if (in_data.subn) begin
            exp_next  = 11'(q >> in_data.f);
            frac_next = 52'(q) & fmask;
        end else if (xr > bias) begin
            exp_next = allones;
            ovf_next = 1'b1;
        end else begin
            exp_next  = 11'(xr + bias);
            frac_next = 52'(carry ? (q >> 1) : q) & fmask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            sign_reg <= sign_next;
            exp_reg  <= exp_next;
            frac_reg <= frac_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sign  = sign_reg;
    assign out_exp   = exp_reg;
    assign out_frac  = frac_reg;
    assign out_ovf   = ovf_reg;

endmodule

[test/double_to_custom_float_checker.sv]
`timescale 1ns / 1ps

module double_to_custom_float_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_value_bits,
    input  logic [3:0]  s_exp_bits,
    input  logic [5:0]  s_frac_bits,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_sign_out,
    input  logic [10:0] m_exponent_field,
    input  logic [51:0] m_fraction_field,
    input  logic        m_overflowed,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    typedef struct packed {
        logic        sign;
        logic [10:0] expf;
        logic [51:0] frac;
        logic        ovf;
    } minifloat_t;

    minifloat_t converted_q[$];

    // Shift right with round to nearest, ties to even
    function automatic logic [63:0] shift_rne(logic [63:0] v, int s);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (s <= 0) return v;
        if (s >= 64) return 64'd0;
        q = v >> s;
        rem = v & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
        return q;
    endfunction

    function automatic minifloat_t convert(logic [63:0] v, logic [3:0] eb, logic [5:0] fb);
        minifloat_t r;
        int e;
        int f;
        int dexp;
        int bias;
        int emin;
        int p;
        int x;
        int s;
        int ue;
        logic [51:0] mant;
        logic [63:0] fmask;
        logic [63:0] allones;
        logic [63:0] sig;
        logic [63:0] q;
        e = int'(eb);
        f = int'(fb);
        if (e < 2) e = 2;
        if (e > 11) e = 11;
        if (f < 1) f = 1;
        if (f > 52) f = 52;
        fmask = (64'd1 << f) - 64'd1;
        allones = (64'd1 << e) - 64'd1;
        bias = (1 << (e - 1)) - 1;
        emin = 1 - bias;
        dexp = int'(v[62:52]);
        mant = v[51:0];
        r = '0;
        r.sign = v[63];
        if (dexp == 2047) begin
            r.expf = allones[10:0];
            if (mant != 0) begin
                q = (64'(mant) >> (52 - f)) & fmask;
                if (q == 0) q = 64'd1 << (f - 1);
                r.frac = q[51:0];
            end
        end else if (!(dexp == 0 && mant == 0)) begin
            if (dexp == 0) begin
                sig = 64'(mant);
                ue = -1022;
            end else begin
                sig = {12'd1, mant};
                ue = dexp - 1023;
            end
            p = 0;
            while (p < 63 && (sig >> (p + 1)) != 0) p++;
            x = ue - 52 + p;
            if (x >= emin) begin
                s = p - f;
                q = (s <= 0) ? (sig << (-s)) : shift_rne(sig, s);
                if ((q >> (f + 1)) != 0) begin
                    q = q >> 1;
                    x++;
                end
                if (x > bias) begin
                    r.expf = allones[10:0];
                    r.ovf = 1'b1;
                end else begin
                    r.expf = 11'(x + bias);
                    r.frac = 52'(q & fmask);
                end
            end else begin
                s = (emin - f) - (ue - 52);
                q = (s <= 0) ? (sig << (-s)) : shift_rne(sig, s);
                r.expf = 11'(q >> f);
                r.frac = 52'(q & fmask);
            end
        end
        return r;
    endfunction

    assign pending_count = converted_q.size();

    // Predict on input transactions, compare on result transactions
    always @(posedge aclk) begin
        minifloat_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            converted_q.delete();
        end else begin
            if (s_valid && s_ready)
                converted_q.push_back(convert(s_value_bits, s_exp_bits, s_frac_bits));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (converted_q.size() == 0) begin
                    $error("result with nothing expected");
                    errs++;
                end else begin
                    want = converted_q.pop_front();
                    if (m_sign_out !== want.sign) begin
                        $error("sign_out: expected %0h, got %0h", want.sign, m_sign_out);
                        errs++;
                    end
                    if (m_exponent_field !== want.expf) begin
                        $error("exponent_field: expected %0h, got %0h",
                               want.expf, m_exponent_field);
                        errs++;
                    end
                    if (m_fraction_field !== want.frac) begin
                        $error("fraction_field: expected %0h, got %0h",
                               want.frac, m_fraction_field);
                        errs++;
                    end
                    if (m_overflowed !== want.ovf) begin
                        $error("overflowed: expected %0h, got %0h", want.ovf, m_overflowed);
                        errs++;
                    end
                end
            end
            // Add all mismatches of this transaction at once
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

[test/double_to_custom_float_test.sv]
`timescale 1ns / 1ps

module double_to_custom_float_test;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_value_bits = '0;
    logic [3:0]  s_exp_bits = 4'd2;
    logic [5:0]  s_frac_bits = 6'd1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_sign_out;
    logic [10:0] m_exponent_field;
    logic [51:0] m_fraction_field;
    logic        m_overflowed;
    int          fail_count;
    int          pending_count;
    int          result_count;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          sent_count = 0;

    always #2 aclk = ~aclk;

    double_to_custom_float dut (.*);

    double_to_custom_float_checker checker_i (.*);

    // Receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one transaction and hold it until accepted
    task automatic send_value(logic [63:0] v, logic [3:0] eb, logic [5:0] fb);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value_bits <= v;
        s_exp_bits <= eb;
        s_frac_bits <= fb;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
    endtask

    // Random binary64 pattern weighted toward edges of the target range
    function automatic logic [63:0] random_double(int eb);
        logic [63:0] v;
        int bias;
        int k;
        v = {$urandom, $urandom};
        bias = (1 << (eb - 1)) - 1;
        k = $urandom_range(9);
        if (k < 5)
            v[62:52] = 11'(1023 + $signed($urandom_range(2 * bias + 60)) - bias - 58);
        else if (k == 5)
            v[62:52] = 11'd0;
        else if (k == 6)
            v[62:52] = 11'h7FF;
        else if (k == 7)
            v[51:0] = $urandom_range(1) ? '0 : {2'($urandom_range(3)), 50'h0};
        return v;
    endfunction

    task automatic random_phase(int n);
        int eb;
        int fb;
        for (int i = 0; i < n; i++) begin
            eb = $urandom_range(2, 11);
            fb = ($urandom_range(3) == 0) ? $urandom_range(1, 52) : $urandom_range(1, 12);
            if ($urandom_range(19) == 0) begin
                eb = $urandom_range(15);
                fb = $urandom_range(63);
            end
            send_value(random_double(eb), 4'(eb), 6'(fb));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zeros, extremes, specials, ties, overflow, out-of-range formats
        send_value(64'h0000_0000_0000_0000, 4'd5, 6'd10);
        send_value(64'h8000_0000_0000_0000, 4'd5, 6'd10);
        send_value(64'h7FF0_0000_0000_0000, 4'd8, 6'd23);
        send_value(64'hFFF0_0000_0000_0000, 4'd2, 6'd1);
        send_value(64'h7FF8_0000_0000_0000, 4'd5, 6'd10);
        send_value(64'h7FF0_0000_0000_0001, 4'd5, 6'd10);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 4'd11, 6'd52);
        send_value(64'h7FEF_FFFF_FFFF_FFFF, 4'd11, 6'd52);
        send_value(64'h7FEF_FFFF_FFFF_FFFF, 4'd5, 6'd10);
        send_value(64'h0000_0000_0000_0001, 4'd11, 6'd52);
        send_value(64'h0000_0000_0000_0001, 4'd2, 6'd1);
        send_value(64'h3FF8_0000_0000_0000, 4'd2, 6'd1);
        send_value(64'h4004_0000_0000_0000, 4'd3, 6'd1);
        send_value(64'h3FF0_0000_0000_0000, 4'd0, 6'd0);
        send_value(64'h3FF0_0000_0000_0000, 4'd15, 6'd63);
        send_value(64'h40EF_FFE0_0000_0000, 4'd5, 6'd10);
        send_value(64'h40EF_FF00_0000_0000, 4'd5, 6'd10);
        send_value(64'h3E70_0000_0000_0000, 4'd5, 6'd10);
        send_value(64'h3E60_0000_0000_0000, 4'd5, 6'd10);
        send_value(64'h3F0F_FC00_0000_0000, 4'd5, 6'd10);
        send_value(64'h000F_FFFF_FFFF_FFFF, 4'd11, 6'd51);
        send_value(64'h5555_5555_5555_5555, 4'd11, 6'd40);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 4'd7, 6'd33);

        send_idle_pct = 18;
        recv_idle_pct = 75;
        random_phase(550);
        send_idle_pct = 75;
        recv_idle_pct = 18;
        random_phase(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(550);
        s_valid <= 1'b0;

        while (pending_count != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("sent %0d conversions, checked %0d results", sent_count, result_count);
        $display("covered signed zero, infinity, NaN, overflow, subnormal, ties and clamping");
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
